>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the single-wire bus master.
// Standalone header; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, clk, rst_n, prop)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/owbm_pkg.sv
// Shared types and constants of the single-wire bus master.
// No dependencies; used by the channel interfaces and the top level.
package owbm_pkg;

    localparam int COUNT_WIDTH_DEF = 10;
    localparam int BITS_PER_BYTE   = 8;
    localparam int BIT_IDX_W       = $clog2(BITS_PER_BYTE);
    localparam int CFG_W           = 10;
    localparam int SHORT_W         = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int REQ_W           = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_RESET = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW     = 3'd0,
        CFG_PRESENCE_WAIT = 3'd1,
        CFG_RESET_TAIL    = 3'd2,
        CFG_SLOT_LOW      = 3'd3,
        CFG_WRITE_SLOT    = 3'd4,
        CFG_READ_SAMPLE   = 3'd5,
        CFG_READ_TAIL     = 3'd6,
        CFG_RECOVERY      = 3'd7
    } t_cfg_idx;

    localparam logic [CFG_W-1:0]   RST_RESET_LOW     = 10'd500;
    localparam logic [CFG_W-1:0]   RST_PRESENCE_WAIT = 10'd70;
    localparam logic [CFG_W-1:0]   RST_RESET_TAIL    = 10'd500;
    localparam logic [SHORT_W-1:0] RST_SLOT_LOW      = 4'd1;
    localparam logic [CFG_W-1:0]   RST_WRITE_SLOT    = 10'd50;
    localparam logic [CFG_W-1:0]   RST_READ_SAMPLE   = 10'd6;
    localparam logic [CFG_W-1:0]   RST_READ_TAIL     = 10'd60;
    localparam logic [SHORT_W-1:0] RST_RECOVERY      = 4'd1;

    typedef enum logic [11:0] {
        PH_IDLE     = 12'b0000_0000_0001,
        PH_RST_LOW  = 12'b0000_0000_0010,
        PH_RST_WAIT = 12'b0000_0000_0100,
        PH_RST_SAMP = 12'b0000_0000_1000,
        PH_RST_TAIL = 12'b0000_0001_0000,
        PH_WR_SLOT  = 12'b0000_0010_0000,
        PH_WR_REC   = 12'b0000_0100_0000,
        PH_RD_LOW   = 12'b0000_1000_0000,
        PH_RD_WAIT  = 12'b0001_0000_0000,
        PH_RD_SAMP  = 12'b0010_0000_0000,
        PH_RD_TAIL  = 12'b0100_0000_0000,
        PH_RD_REC   = 12'b1000_0000_0000
    } t_phase;

endpackage

>>> hw/rtl/owbm_if.sv
// Valid/ready channel interfaces of the single-wire bus master: tick input,
// per-tick result and register write. Depends on owbm_pkg.
interface owbm_in_if;
    logic                           valid;
    logic                           ready;
    logic [owbm_pkg::REQ_W-1:0]     req_type;
    logic [owbm_pkg::BITS_PER_BYTE-1:0] data_byte;
    logic                           line_in;

    modport source (output valid, req_type, data_byte, line_in, input ready);
    modport sink   (input valid, req_type, data_byte, line_in, output ready);
endinterface

interface owbm_out_if;
    logic                           valid;
    logic                           ready;
    logic                           drive_low;
    logic                           busy_res;
    logic                           done_res;
    logic [owbm_pkg::BITS_PER_BYTE-1:0] read_byte;
    logic                           presence;

    modport source (output valid, drive_low, busy_res, done_res, read_byte, presence,
                    input ready);
    modport sink   (input valid, drive_low, busy_res, done_res, read_byte, presence,
                    output ready);
endinterface

interface owbm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [owbm_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [owbm_pkg::CFG_W-1:0]     wr_data;

    modport source (output valid, reg_idx, wr_data, input ready);
    modport sink   (input valid, reg_idx, wr_data, output ready);
endinterface

>>> hw/rtl/one_wire_bus_master.sv
// Single-wire bus master: one input transfer is one microsecond tick and gives
// exactly one result transfer with the line drive, busy, done, last read byte and
// presence flag. Every tick is handled combinationally between the state
// registers and the result register, so a tick can be taken every cycle while
// the result is not stalled; the result appears in the cycle after its transfer,
// and the only stall is a full result register whose sink is not ready. Timing
// registers are written through the configuration channel, which is always ready.
// Depends on owbm_pkg, owbm_if.sv and assert_macros.svh.
`include "assert_macros.svh"

module one_wire_bus_master #(
    parameter int COUNT_WIDTH = owbm_pkg::COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    owbm_in_if.sink    i_req,
    owbm_cfg_if.sink   i_cfg,
    owbm_out_if.source o_res
);

    localparam int CW = COUNT_WIDTH;
    localparam int NB = owbm_pkg::BITS_PER_BYTE;
    localparam int BW = owbm_pkg::BIT_IDX_W;
    localparam int FW = owbm_pkg::CFG_W;
    localparam int SW = owbm_pkg::SHORT_W;
    localparam logic [CW-1:0] COUNT_MAX = '1;

    typedef struct packed {
        owbm_pkg::t_phase phase;
        logic [BW-1:0]    bi;
        logic [NB-1:0]    sb;
        logic [NB-1:0]    rx;
    } t_walk;

    logic [FW-1:0] r_cfg_reset_low, r_cfg_presence_wait, r_cfg_reset_tail;
    logic [FW-1:0] r_cfg_write_slot, r_cfg_read_sample, r_cfg_read_tail;
    logic [SW-1:0] r_cfg_slot_low, r_cfg_recovery;

    owbm_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [BW-1:0]    r_bi, n_bi;
    logic [NB-1:0]    r_sb, n_sb;
    logic [NB-1:0]    r_rx, n_rx;
    logic             r_pres, n_pres;

    logic             r_out_valid;
    logic             r_drive, n_drive;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic             in_acc;
    logic             start;
    t_walk            w;
    logic [CW-1:0]    cnt;

    function automatic logic [FW-1:0] at_least_one(logic [FW-1:0] v);
        return (v == '0) ? FW'(1) : v;
    endfunction

    function automatic logic [CW-1:0] sat(logic [FW-1:0] v);
        logic [FW+CW-1:0] wide;
        wide = {{CW{1'b0}}, v};
        if (wide > {{FW{1'b0}}, COUNT_MAX}) begin
            return COUNT_MAX;
        end
        return wide[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] phase_len(owbm_pkg::t_phase p);
        logic [CW-1:0] n;
        case (p)
            owbm_pkg::PH_RST_LOW:  n = sat(at_least_one(r_cfg_reset_low));
            owbm_pkg::PH_RST_WAIT: n = sat(at_least_one(r_cfg_presence_wait));
            owbm_pkg::PH_RST_TAIL: n = sat(r_cfg_reset_tail);
            owbm_pkg::PH_WR_SLOT:  n = sat(at_least_one(r_cfg_write_slot));
            owbm_pkg::PH_RD_LOW:   n = sat(at_least_one({{(FW-SW){1'b0}}, r_cfg_slot_low}));
            owbm_pkg::PH_RD_WAIT:  n = sat(r_cfg_read_sample);
            owbm_pkg::PH_RD_TAIL:  n = sat(r_cfg_read_tail);
            owbm_pkg::PH_WR_REC,
            owbm_pkg::PH_RD_REC:   n = sat({{(FW-SW){1'b0}}, r_cfg_recovery});
            owbm_pkg::PH_RST_SAMP,
            owbm_pkg::PH_RD_SAMP:  n = CW'(1);
            default:               n = '0;
        endcase
        return n;
    endfunction

    function automatic t_walk leave(t_walk v);
        t_walk r;
        logic  last;
        r    = v;
        last = (v.bi == BW'(NB - 1));
        case (v.phase)
            owbm_pkg::PH_RST_LOW:  r.phase = owbm_pkg::PH_RST_WAIT;
            owbm_pkg::PH_RST_WAIT: r.phase = owbm_pkg::PH_RST_SAMP;
            owbm_pkg::PH_RST_SAMP: r.phase = owbm_pkg::PH_RST_TAIL;
            owbm_pkg::PH_WR_SLOT: begin
                if (last) begin
                    r.phase = owbm_pkg::PH_IDLE;
                end else begin
                    r.bi    = v.bi + 1'b1;
                    r.sb    = {1'b0, v.sb[NB-1:1]};
                    r.phase = owbm_pkg::PH_WR_REC;
                end
            end
            owbm_pkg::PH_WR_REC:   r.phase = owbm_pkg::PH_WR_SLOT;
            owbm_pkg::PH_RD_LOW:   r.phase = owbm_pkg::PH_RD_WAIT;
            owbm_pkg::PH_RD_WAIT:  r.phase = owbm_pkg::PH_RD_SAMP;
            owbm_pkg::PH_RD_SAMP:  r.phase = owbm_pkg::PH_RD_TAIL;
            owbm_pkg::PH_RD_TAIL: begin
                if (last) begin
                    r.rx    = v.sb;
                    r.phase = owbm_pkg::PH_IDLE;
                end else begin
                    r.bi    = v.bi + 1'b1;
                    r.phase = owbm_pkg::PH_RD_REC;
                end
            end
            owbm_pkg::PH_RD_REC:   r.phase = owbm_pkg::PH_RD_LOW;
            default:               r.phase = owbm_pkg::PH_IDLE;
        endcase
        return r;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign in_acc      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_reset_low     <= owbm_pkg::RST_RESET_LOW;
            r_cfg_presence_wait <= owbm_pkg::RST_PRESENCE_WAIT;
            r_cfg_reset_tail    <= owbm_pkg::RST_RESET_TAIL;
            r_cfg_slot_low      <= owbm_pkg::RST_SLOT_LOW;
            r_cfg_write_slot    <= owbm_pkg::RST_WRITE_SLOT;
            r_cfg_read_sample   <= owbm_pkg::RST_READ_SAMPLE;
            r_cfg_read_tail     <= owbm_pkg::RST_READ_TAIL;
            r_cfg_recovery      <= owbm_pkg::RST_RECOVERY;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (owbm_pkg::t_cfg_idx'(i_cfg.reg_idx))
                owbm_pkg::CFG_RESET_LOW:     r_cfg_reset_low     <= i_cfg.wr_data;
                owbm_pkg::CFG_PRESENCE_WAIT: r_cfg_presence_wait <= i_cfg.wr_data;
                owbm_pkg::CFG_RESET_TAIL:    r_cfg_reset_tail    <= i_cfg.wr_data;
                owbm_pkg::CFG_SLOT_LOW:      r_cfg_slot_low      <= i_cfg.wr_data[SW-1:0];
                owbm_pkg::CFG_WRITE_SLOT:    r_cfg_write_slot    <= i_cfg.wr_data;
                owbm_pkg::CFG_READ_SAMPLE:   r_cfg_read_sample   <= i_cfg.wr_data;
                owbm_pkg::CFG_READ_TAIL:     r_cfg_read_tail     <= i_cfg.wr_data;
                owbm_pkg::CFG_RECOVERY:      r_cfg_recovery      <= i_cfg.wr_data[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        start    = (r_phase == owbm_pkg::PH_IDLE) &&
                   (owbm_pkg::t_req'(i_req.req_type) != owbm_pkg::REQ_TICK);
        w.phase  = r_phase;
        w.bi     = r_bi;
        w.sb     = r_sb;
        w.rx     = r_rx;
        cnt      = r_cnt;
        n_pres   = r_pres;
        n_drive  = 1'b0;
        n_busy   = 1'b0;
        n_done   = 1'b0;

        if (start) begin
            cnt  = '0;
            w.bi = '0;
            case (owbm_pkg::t_req'(i_req.req_type))
                owbm_pkg::REQ_RESET: begin
                    w.phase = owbm_pkg::PH_RST_LOW;
                    w.sb    = '0;
                end
                owbm_pkg::REQ_WRITE: begin
                    w.phase = owbm_pkg::PH_WR_SLOT;
                    w.sb    = i_req.data_byte;
                end
                default: begin
                    w.phase = owbm_pkg::PH_RD_LOW;
                    w.sb    = '0;
                end
            endcase
        end

        if (w.phase != owbm_pkg::PH_IDLE) begin
            n_busy = 1'b1;
            case (w.phase)
                owbm_pkg::PH_RST_LOW,
                owbm_pkg::PH_RD_LOW:   n_drive = 1'b1;
                owbm_pkg::PH_WR_SLOT:  n_drive = w.sb[0] ?
                    (cnt < CW'(at_least_one({{(FW-SW){1'b0}}, r_cfg_slot_low}))) : 1'b1;
                owbm_pkg::PH_RST_SAMP: n_pres = !i_req.line_in;
                owbm_pkg::PH_RD_SAMP:  w.sb = {i_req.line_in, w.sb[NB-1:1]};
                default: ;
            endcase
            cnt = cnt + 1'b1;
            if (cnt >= phase_len(w.phase)) begin
                w   = leave(w);
                cnt = '0;
                // zero-length waits fall through, at most two in a row
                for (int k = 0; k < 2; k++) begin
                    if (w.phase != owbm_pkg::PH_IDLE && phase_len(w.phase) == '0) begin
                        w = leave(w);
                    end
                end
                n_done = (w.phase == owbm_pkg::PH_IDLE);
            end
        end

        n_phase = w.phase;
        n_cnt   = cnt;
        n_bi    = w.bi;
        n_sb    = w.sb;
        n_rx    = w.rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= owbm_pkg::PH_IDLE;
            r_cnt       <= '0;
            r_bi        <= '0;
            r_sb        <= '0;
            r_rx        <= '0;
            r_pres      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_bi        <= n_bi;
            r_sb        <= n_sb;
            r_rx        <= n_rx;
            r_pres      <= n_pres;
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_drive <= n_drive;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.drive_low = r_drive;
    assign o_res.busy_res  = r_busy;
    assign o_res.done_res  = r_done;
    assign o_res.read_byte = r_rx;
    assign o_res.presence  = r_pres;

    `ASSERT_ALWAYS(a_phase_onehot, i_clk, i_rst_n, $onehot(r_phase))
    `ASSERT_ALWAYS(a_done_idle, i_clk, i_rst_n, !(r_out_valid && r_done) || (r_phase == owbm_pkg::PH_IDLE))
    `ASSERT_NEXT(a_idle_quiet, i_clk, i_rst_n, in_acc && !start && r_phase == owbm_pkg::PH_IDLE, !r_busy && !r_drive && !r_done)

endmodule
